FILE: rtl/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 32;
    localparam int SUM_W    = 34;
    localparam int EDGE_W   = 2 * VERTEX_W + WEIGHT_W;

    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_SOURCE_VERTEX = 1'b1;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

endpackage

FILE: rtl/ssp_ram.sv
`timescale 1ns / 1ps

module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/single_source_shortest_paths_unit.sv
`timescale 1ns / 1ps

// Bellman-Ford shortest paths. An add item (func 0) stores one edge, so edges may be loaded
// on every cycle while busy is low; edges beyond MAX_EDGES are dropped and flagged. A solve
// item (func 1) keeps busy high while it runs. The distance memory, which also holds the
// reachable mark of each vertex, is first cleared one vertex per cycle. Then each edge of
// each pass reads the edge memory, then the source and target words through the single read
// port of the distance memory, then writes the target back when its path improves, except in
// the final check pass; an edge with an endpoint outside the vertex range is dropped without
// reading its target word. Results then come out one per cycle on out_valid, once per vertex,
// or as one negative-cycle result, the last one in the first cycle that busy is low; they
// cannot be held off and must be taken as they appear.
module single_source_shortest_paths_unit #(
    parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [5:0]  edge_source,
    input  logic [5:0]  edge_target,
    input  logic signed [15:0] edge_weight,
    output logic        out_valid,
    output logic [5:0]  vertex,
    output logic signed [31:0] path_length,
    output logic        reachable,
    output logic        negative_cycle,
    output logic        edges_dropped,
    output logic        last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int CW = ssp_pkg::COUNT_W;
    localparam int SW = ssp_pkg::SUM_W;
    localparam int DW = ssp_pkg::DIST_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b00000001,
        ST_CLEAR   = 8'b00000010,
        ST_RD_EDGE = 8'b00000100,
        ST_RD_SRC  = 8'b00001000,
        ST_RD_TGT  = 8'b00010000,
        ST_UPDATE  = 8'b00100000,
        ST_EMIT    = 8'b01000000,
        ST_CYCLE   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] vertex_count_reg;
    logic [5:0]    source_vertex_reg;
    logic [EW-1:0] edge_total_reg;
    logic          overflow_reg;
    logic [CW-1:0] nv_reg;
    logic [CW-1:0] pass_reg;
    logic [AW-1:0] k_reg;
    logic [VW-1:0] emit_v_reg;
    logic          drop_reg;
    logic          cycle_reg;
    logic          src_reach_reg;
    logic [ssp_pkg::EDGE_W-1:0] edge_reg;
    logic signed [SW-1:0] sum_reg;

    logic          pend_reg;
    logic [5:0]    pend_vertex_reg;
    logic          pend_emit_reg;
    logic          pend_neg_reg;
    logic          pend_last_reg;

    logic                       edge_we;
    logic [ssp_pkg::EDGE_W-1:0] edge_rdata;
    logic                       dist_we;
    logic [VW-1:0]              dist_waddr;
    logic [DW-1:0]              dist_wdata;
    logic [VW-1:0]              dist_raddr;
    logic [DW-1:0]              dist_rdata;

    logic [CW-1:0] nv_clamp;
    logic          solve_go;
    logic          add_go;
    logic [5:0]    e_src;
    logic [5:0]    e_tgt;
    logic [5:0]    r_tgt;
    logic          edge_ok;
    logic          last_edge;
    logic          check_pass;
    logic          improve;
    logic          emit_last;
    logic          clr_reach;
    logic [31:0]   sat_sum;

    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);
    assign prdata = (paddr[2] == ssp_pkg::REG_VERTEX_COUNT) ? {25'd0, vertex_count_reg}
                                                         : {26'd0, source_vertex_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= CW'(1);
            source_vertex_reg <= 6'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == ssp_pkg::REG_VERTEX_COUNT)
            begin
                vertex_count_reg <= pwdata[CW-1:0];
            end
            else
            begin
                source_vertex_reg <= pwdata[5:0];
            end
        end
    end

    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            nv_clamp = CW'(1);
        end
        else if (vertex_count_reg > CW'(MAX_VERTICES))
        begin
            nv_clamp = CW'(MAX_VERTICES);
        end
        else
        begin
            nv_clamp = vertex_count_reg;
        end
    end

    assign solve_go     = start && !busy && (func == ssp_pkg::FUNC_SOLVE);
    assign add_go       = start && !busy && (func == ssp_pkg::FUNC_ADD);
    assign edge_we      = add_go && (edge_total_reg < EW'(MAX_EDGES));

    assign e_src      = edge_rdata[5:0];
    assign e_tgt      = edge_rdata[11:6];
    assign r_tgt      = edge_reg[11:6];
    assign edge_ok    = ({1'b0, e_src} < nv_reg) && ({1'b0, e_tgt} < nv_reg);
    assign last_edge  = ((EW'(k_reg) + EW'(1)) == edge_total_reg);
    assign check_pass = (pass_reg == (nv_reg - CW'(1)));
    assign improve    = src_reach_reg
                        && (!dist_rdata[DW-1]
                            || (sum_reg < SW'($signed(dist_rdata[DW-2:0]))));
    assign emit_last  = ((CW'(emit_v_reg) + CW'(1)) == nv_reg);
    assign clr_reach  = (CW'(emit_v_reg) == {1'b0, source_vertex_reg});

    always_comb
    begin
        if (sum_reg[SW-1:31] == '0 || sum_reg[SW-1:31] == '1)
        begin
            sat_sum = sum_reg[31:0];
        end
        else if (sum_reg[SW-1])
        begin
            sat_sum = 32'h8000_0000;
        end
        else
        begin
            sat_sum = 32'h7fff_ffff;
        end
    end

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = emit_v_reg;
        dist_wdata = '0;
        dist_raddr = emit_v_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                dist_we    = 1'b1;
                dist_wdata = {clr_reach, 32'd0};
            end
            ST_RD_SRC:
            begin
                dist_raddr = e_src[VW-1:0];
            end
            ST_RD_TGT:
            begin
                dist_raddr = r_tgt[VW-1:0];
            end
            ST_UPDATE:
            begin
                dist_we    = improve && !check_pass;
                dist_waddr = r_tgt[VW-1:0];
                dist_wdata = {1'b1, sat_sum};
            end
            default:
            begin
                dist_raddr = emit_v_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (solve_go)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (emit_last)
                begin
                    state_next = (edge_total_reg == '0) ? ST_EMIT : ST_RD_EDGE;
                end
            end
            ST_RD_EDGE: state_next = ST_RD_SRC;
            ST_RD_SRC:
            begin
                if (edge_ok)
                begin
                    state_next = ST_RD_TGT;
                end
                else if (last_edge && check_pass)
                begin
                    state_next = cycle_reg ? ST_CYCLE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD_EDGE;
                end
            end
            ST_RD_TGT: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (last_edge && check_pass)
                begin
                    state_next = (cycle_reg || improve) ? ST_CYCLE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD_EDGE;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CYCLE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            nv_reg         <= CW'(1);
            pass_reg       <= '0;
            k_reg          <= '0;
            emit_v_reg     <= '0;
            drop_reg       <= 1'b0;
            cycle_reg      <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (edge_we)
                    begin
                        edge_total_reg <= edge_total_reg + EW'(1);
                    end
                    else if (add_go)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    if (solve_go)
                    begin
                        nv_reg       <= nv_clamp;
                        pass_reg     <= '0;
                        k_reg        <= '0;
                        emit_v_reg   <= '0;
                        cycle_reg    <= 1'b0;
                        drop_reg     <= overflow_reg;
                        overflow_reg <= 1'b0;
                    end
                end
                ST_CLEAR:
                begin
                    emit_v_reg <= emit_last ? '0 : emit_v_reg + VW'(1);
                end
                ST_RD_SRC, ST_UPDATE:
                begin
                    if (state_reg == ST_UPDATE && improve && check_pass)
                    begin
                        cycle_reg <= 1'b1;
                    end
                    if (state_reg == ST_UPDATE || !edge_ok)
                    begin
                        if (last_edge)
                        begin
                            k_reg    <= '0;
                            pass_reg <= pass_reg + CW'(1);
                        end
                        else
                        begin
                            k_reg <= k_reg + AW'(1);
                        end
                    end
                end
                ST_EMIT:
                begin
                    pend_reg   <= 1'b1;
                    emit_v_reg <= emit_v_reg + VW'(1);
                    if (state_next == ST_IDLE)
                    begin
                        edge_total_reg <= '0;
                    end
                end
                ST_CYCLE:
                begin
                    pend_reg       <= 1'b1;
                    edge_total_reg <= '0;
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_SRC)
        begin
            edge_reg <= edge_rdata;
        end
        if (state_reg == ST_RD_TGT)
        begin
            src_reach_reg <= dist_rdata[DW-1];
            sum_reg       <= SW'($signed(dist_rdata[DW-2:0])) + SW'($signed(edge_reg[27:12]));
        end
        pend_vertex_reg <= (state_reg == ST_CYCLE) ? 6'd0 : 6'(emit_v_reg);
        pend_emit_reg   <= (state_reg == ST_EMIT);
        pend_neg_reg    <= (state_reg == ST_CYCLE);
        pend_last_reg   <= (state_reg == ST_CYCLE) || emit_last;
    end

    assign out_valid      = pend_reg;
    assign vertex         = pend_vertex_reg;
    assign reachable      = pend_emit_reg && dist_rdata[DW-1];
    assign path_length    = reachable ? $signed(dist_rdata[DW-2:0]) : 32'sd0;
    assign negative_cycle = pend_neg_reg;
    assign edges_dropped  = drop_reg;
    assign last           = pend_last_reg;

    ssp_ram #(
        .WIDTH(ssp_pkg::EDGE_W),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .clk  (clk),
        .we   (edge_we),
        .waddr(edge_total_reg[AW-1:0]),
        .wdata({edge_weight, edge_target, edge_source}),
        .raddr(k_reg),
        .rdata(edge_rdata)
    );

    ssp_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_VERTICES)
    ) u_dist_ram (
        .clk  (clk),
        .we   (dist_we),
        .waddr(dist_waddr),
        .wdata(dist_wdata),
        .raddr(dist_raddr),
        .rdata(dist_rdata)
    );

endmodule

FILE: rtl/ssp_checker.sv
`timescale 1ns / 1ps

module ssp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        func,
    input logic        out_valid,
    input logic signed [31:0] path_length,
    input logic        reachable,
    input logic        negative_cycle,
    input logic        last
);

    a_neg_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && negative_cycle |-> last && !reachable && path_length == 0)
        else $error("negative cycle item malformed");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reachable |-> path_length == 0)
        else $error("unreachable item with nonzero length");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == ssp_pkg::FUNC_SOLVE |=> busy)
        else $error("solve did not raise busy");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("gap inside result burst");

endmodule

bind single_source_shortest_paths_unit ssp_checker u_ssp_checker (.*);
